/* hw/rtl/rc_link_frame_receiver_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the RC link frame receiver
// Shared concurrent checks, clocked on the rising edge, reset disables.
// ---------------------------------------------------------------------------
`ifndef RC_LINK_FRAME_RECEIVER_ASSERT_SVH
`define RC_LINK_FRAME_RECEIVER_ASSERT_SVH

// ante implies cons in the same cycle
`define RCLFR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rclfr assertion failed");

// cond holds at every edge out of reset
`define RCLFR_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
  `RCLFR_ASSERT_IMPL(lbl, clk_s, rstn_s, 1'b1, cond)

`endif

/* hw/rtl/rclfr_pkg.sv */
// ---------------------------------------------------------------------------
// rclfr_pkg
// Constants, codes and shared types of the RC link frame receiver.
// ---------------------------------------------------------------------------
package rclfr_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int NUM_CHANNELS    = 16;
  localparam int CH_W            = 11;
  localparam int PAYLOAD_BYTES   = 22;
  localparam int PAYLOAD_AW      = $clog2(PAYLOAD_BYTES);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [7:0]  SYNC_MARK  = 8'hC8;
  localparam logic [7:0]  TYPE_RC    = 8'h16;
  localparam logic [7:0]  CRC_POLY   = 8'hD5;
  localparam logic [7:0]  LEN_MIN    = 8'd2;
  localparam logic [7:0]  LEN_MAX    = 8'(MAX_FRAME_BYTES - 2);
  localparam logic [5:0]  MIN_RC_LEN = 6'd24;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_BADLEN = 2'd1,
    ST_DROP  = 2'd2,
    ST_ACCEPT = 2'd3
  } frame_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_CH_DEFAULT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] crc;
  } crc_stat_t;

endpackage

/* hw/rtl/rclfr_ram.sv */
// ---------------------------------------------------------------------------
// rclfr_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module rclfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/rclfr_crc_unit.sv */
// ---------------------------------------------------------------------------
// rclfr_crc_unit
// Bit-serial CRC-8 (poly 0xD5), one bit per cycle.
// ---------------------------------------------------------------------------
module rclfr_crc_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rclfr_pkg::crc_cmd_t  cmd,
  output rclfr_pkg::crc_stat_t stat
);
  import rclfr_pkg::*;

  logic [7:0] crc_r;
  logic [3:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'd0;
      cnt_r <= 4'd0;
    end else begin
      priority if (cmd.clear) begin
        crc_r <= 8'd0;
        cnt_r <= 4'd0;
      end else if (cmd.load) begin
        crc_r <= crc_r ^ cmd.data;
        cnt_r <= 4'd8;
      end else if (cnt_r != 4'd0) begin
        crc_r <= crc_r[7] ? ({crc_r[6:0], 1'b0} ^ CRC_POLY) : {crc_r[6:0], 1'b0};
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  assign stat.busy = (cnt_r != 4'd0);
  assign stat.crc  = crc_r;

endmodule

/* hw/rtl/rc_link_frame_receiver.sv */
// ---------------------------------------------------------------------------
// rc_link_frame_receiver
// Frame parser for RC link channel frames with failsafe timer.
// ---------------------------------------------------------------------------
// Input words carry a UART byte (action 0) or a 1 ms tick (action 1).
// Every input word yields one status word; a frame that passes sync,
// length, CRC-8 and type checks yields 16 more channel words, index 0 up,
// with last set on the final word of the run.
// The status word is registered in S_STATUS after accept, once the output
// register is free. A payload or type byte keeps in_stall high also while
// the serial CRC unit runs its 8 bit steps. An accepted frame then unpacks
// 22 payload bytes from the payload RAM, each byte read in S_RD and appended
// in S_APPEND, and each channel word loaded in S_EMIT when the output
// register is free.
// One input word is in work at a time; in_stall is high until its last
// result sits in the output register and the serial CRC unit is done.
// out_stall holds the output register; the sequencer waits on it.
// Reset: parser hunts for sync, link down, frame count zero, timeout 500.
// Config writes are taken at any time (cfg_ready is tied high).
// ---------------------------------------------------------------------------
module rc_link_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [1:0]                      out_frame_status,
  output logic                            out_link_ok,
  output logic [31:0]                     out_valid_frames,
  output logic [3:0]                      out_channel_index,
  output logic [rclfr_pkg::CH_W-1:0]      out_channel_value,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rclfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rclfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rclfr_pkg::*;
  `include "rc_link_frame_receiver_assert.svh"

  typedef enum logic [2:0] {S_IDLE, S_STATUS, S_RD, S_APPEND, S_EMIT} state_t;
  typedef enum logic [1:0] {PH_SYNC, PH_LEN, PH_DATA} phase_t;

  state_t        state_r;
  phase_t        phase_r;
  logic [5:0]    len_r;
  logic [5:0]    pos_r;
  logic [7:0]    type_r;
  logic [15:0]   since_r;
  logic [31:0]   count_r;
  logic [15:0]   timeout_r;
  frame_status_t status_r;
  logic          acc_r;

  logic [17:0]           bitbuf_r;
  logic [4:0]            bitcnt_r;
  logic [PAYLOAD_AW-1:0] rd_ptr_r;
  logic [3:0]            ch_r;

  logic            out_valid_r;
  logic            out_kind_r;
  logic [1:0]      out_status_r;
  logic            out_link_r;
  logic [31:0]     out_frames_r;
  logic [3:0]      out_idx_r;
  logic [CH_W-1:0] out_value_r;
  logic            out_last_r;

  crc_cmd_t  crc_cmd;
  crc_stat_t crc_st;
  logic [7:0] ram_rdata;

  logic in_acc, out_free, out_load, is_byte, len_ok, more, crc_match, link_now, pl_we;
  logic [4:0] bitcnt_p8, bitcnt_m11;

  assign in_stall  = (state_r != S_IDLE) || crc_st.busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = out_free && ((state_r == S_STATUS) || (state_r == S_EMIT));
  assign is_byte   = in_acc && !in_action;
  assign len_ok    = (in_data_byte >= LEN_MIN) && (in_data_byte <= LEN_MAX);
  assign more      = ({1'b0, pos_r} + 7'd1) < {1'b0, len_r};
  assign crc_match = (crc_st.crc == in_data_byte) && (type_r == TYPE_RC) &&
                     (len_r >= MIN_RC_LEN);
  assign link_now  = since_r < timeout_r;
  assign bitcnt_p8  = bitcnt_r + 5'd8;
  assign bitcnt_m11 = bitcnt_r - 5'(CH_W);

  assign crc_cmd.clear = is_byte && (phase_r == PH_LEN) && len_ok;
  assign crc_cmd.load  = is_byte && (phase_r == PH_DATA) && more;
  assign crc_cmd.data  = in_data_byte;
  assign pl_we = crc_cmd.load && (pos_r != 6'd0) &&
                 (pos_r <= 6'(PAYLOAD_BYTES));

  rclfr_crc_unit u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (crc_cmd),
    .stat (crc_st)
  );

  rclfr_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES),
    .AW   (PAYLOAD_AW)
  ) u_payload (
    .clk  (clk),
    .we   (pl_we),
    .waddr(PAYLOAD_AW'(pos_r - 6'd1)),
    .wdata(in_data_byte),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  // channel default never shows: every accepted frame rewrites all channels
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_SYNC;
      len_r       <= 6'd0;
      pos_r       <= 6'd0;
      type_r      <= 8'd0;
      since_r     <= 16'hFFFF;
      count_r     <= 32'd0;
      status_r    <= ST_NONE;
      acc_r       <= 1'b0;
      bitcnt_r    <= 5'd0;
      rd_ptr_r    <= '0;
      ch_r        <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            status_r <= ST_NONE;
            acc_r    <= 1'b0;
            state_r  <= S_STATUS;
            if (in_action) begin
              if (since_r != 16'hFFFF) begin
                since_r <= since_r + 16'd1;
              end
            end else begin
              unique case (phase_r)
                PH_LEN: begin
                  if (!len_ok) begin
                    status_r <= ST_BADLEN;
                    phase_r  <= PH_SYNC;
                  end else begin
                    len_r   <= in_data_byte[5:0];
                    pos_r   <= 6'd0;
                    phase_r <= PH_DATA;
                  end
                end
                PH_DATA: begin
                  if (more) begin
                    if (pos_r == 6'd0) begin
                      type_r <= in_data_byte;
                    end
                    pos_r <= pos_r + 6'd1;
                  end else begin
                    if (crc_match) begin
                      since_r  <= 16'd0;
                      count_r  <= count_r + 32'd1;
                      acc_r    <= 1'b1;
                      status_r <= ST_ACCEPT;
                    end else begin
                      status_r <= ST_DROP;
                    end
                    phase_r <= PH_SYNC;
                  end
                end
                default: begin
                  if (in_data_byte == SYNC_MARK) begin
                    phase_r <= PH_LEN;
                  end
                end
              endcase
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= 1'b0;
            out_status_r <= status_r;
            out_link_r   <= link_now;
            out_frames_r <= count_r;
            out_idx_r    <= 4'd0;
            out_value_r  <= '0;
            out_last_r   <= !acc_r;
            bitbuf_r     <= 18'd0;
            bitcnt_r     <= 5'd0;
            rd_ptr_r     <= '0;
            ch_r         <= 4'd0;
            state_r      <= acc_r ? S_RD : S_IDLE;
          end
        end
        S_RD: begin
          rd_ptr_r <= rd_ptr_r + PAYLOAD_AW'(1);
          state_r  <= S_APPEND;
        end
        S_APPEND: begin
          bitbuf_r <= bitbuf_r | (18'(ram_rdata) << bitcnt_r);
          bitcnt_r <= bitcnt_p8;
          state_r  <= (bitcnt_p8 >= 5'(CH_W)) ? S_EMIT : S_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= 1'b1;
            out_status_r <= ST_ACCEPT;
            out_link_r   <= link_now;
            out_frames_r <= count_r;
            out_idx_r    <= ch_r;
            out_value_r  <= bitbuf_r[CH_W-1:0];
            out_last_r   <= (ch_r == 4'(NUM_CHANNELS - 1));
            bitbuf_r     <= bitbuf_r >> CH_W;
            bitcnt_r     <= bitcnt_m11;
            ch_r         <= ch_r + 4'd1;
            if (ch_r == 4'(NUM_CHANNELS - 1)) begin
              state_r <= S_IDLE;
            end else if (bitcnt_m11 >= 5'(CH_W)) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_frame_status  = out_status_r;
  assign out_link_ok       = out_link_r;
  assign out_valid_frames  = out_frames_r;
  assign out_channel_index = out_idx_r;
  assign out_channel_value = out_value_r;
  assign out_last          = out_last_r;

  `RCLFR_ASSERT_IMPL(a_crc_not_in_unpack, clk, rst_n, crc_st.busy,
    (state_r != S_RD) && (state_r != S_APPEND) && (state_r != S_EMIT))
  `RCLFR_ASSERT_IMPL(a_last_on_final_channel, clk, rst_n,
    out_valid_r && out_kind_r && out_last_r, out_idx_r == 4'(NUM_CHANNELS - 1))
  `RCLFR_ASSERT_ALWAYS(a_bitcnt_bound, clk, rst_n, bitcnt_r <= 5'd18)
  `RCLFR_ASSERT_ALWAYS(a_rdptr_bound, clk, rst_n, rd_ptr_r <= PAYLOAD_AW'(PAYLOAD_BYTES))

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: RC link frame receiver testbench
// Drives UART bytes and millisecond ticks, predicts every status and channel
// word in a local parser model and checks them in order. A directed table of
// sync, length, short-frame and full-frame cases comes first, then random
// frame traffic under several timeout settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rclfr_pkg::*;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [CH_W-1:0] CH_DEFAULT_RST = 11'd992;
  localparam logic [15:0] SINCE_SAT = 16'hFFFF;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {HUNT_SYNC, TAKE_LEN, TAKE_BODY} rx_phase_t;
  typedef enum logic {ROW_WORD, ROW_FRAME} row_kind_t;

  typedef struct packed {
    logic            kind;
    frame_status_t   status;
    logic            link_ok;
    logic [31:0]     frames;
    logic [3:0]      index;
    logic [CH_W-1:0] value;
    logic            last;
  } rx_result_t;

  // frame rows send a 24-byte channels frame; data fills payload bytes 0-10, ~data the rest
  typedef struct {
    row_kind_t     kind;
    logic          action;
    logic [7:0]    data;
    frame_status_t st;
    logic          link_ok;
    logic [31:0]   frames;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_action;
  logic [7:0]            in_data_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_kind;
  logic [1:0]            out_frame_status;
  logic                  out_link_ok;
  logic [31:0]           out_valid_frames;
  logic [3:0]            out_channel_index;
  logic [CH_W-1:0]       out_channel_value;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state and register copies
  rx_phase_t       rx_phase;
  logic [5:0]      frame_len;
  logic [5:0]      body_pos;
  logic [7:0]      body_crc;
  logic [7:0]      body_type;
  logic [7:0]      pay [PAYLOAD_BYTES];
  logic [CH_W-1:0] chan [NUM_CHANNELS];
  logic [15:0]     since_ms;
  logic [31:0]     frames_ok;
  logic [15:0]     timeout_ms;
  logic [CH_W-1:0] chan_default;

  rx_result_t link_results_q [$];
  rx_result_t seen, want;
  dir_row_t   dir_table [17];

  int words_in;
  int checked;
  int bad_count;
  int send_idle_pct;
  int stall_pct;
  int hold_left;

  rc_link_frame_receiver DUT (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic void predict_link_results(input logic act, input logic [7:0] b);
    frame_status_t st;
    bit            took;
    logic [175:0]  bits;
    rx_result_t    r;
    st = ST_NONE;
    took = 1'b0;
    if (act == ACT_TICK) begin
      if (since_ms != SINCE_SAT) since_ms++;
    end else begin
      case (rx_phase)
        TAKE_LEN: begin
          if (b < LEN_MIN || b > LEN_MAX) begin
            st = ST_BADLEN;
            rx_phase = HUNT_SYNC;
          end else begin
            frame_len = b[5:0];
            body_pos = '0;
            body_crc = '0;
            rx_phase = TAKE_BODY;
          end
        end
        TAKE_BODY: begin
          if (int'(body_pos) + 1 < int'(frame_len)) begin
            if (body_pos == 0) body_type = b;
            else if (int'(body_pos) - 1 < PAYLOAD_BYTES) pay[body_pos - 1] = b;
            body_crc = crc8_next(body_crc, b);
            body_pos++;
          end else begin
            if (body_crc == b && body_type == TYPE_RC && frame_len >= MIN_RC_LEN) begin
              for (int k = 0; k < PAYLOAD_BYTES; k++) bits[k*8 +: 8] = pay[k];
              for (int c = 0; c < NUM_CHANNELS; c++) chan[c] = bits[c*CH_W +: CH_W];
              since_ms = '0;
              frames_ok++;
              took = 1'b1;
              st = ST_ACCEPT;
            end else begin
              st = ST_DROP;
            end
            rx_phase = HUNT_SYNC;
          end
        end
        default: begin
          if (b == SYNC_MARK) rx_phase = TAKE_LEN;
        end
      endcase
    end
    r = '0;
    r.status = st;
    r.link_ok = (since_ms < timeout_ms);
    r.frames = frames_ok;
    r.last = !took;
    link_results_q.push_back(r);
    if (took) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        r.kind = 1'b1;
        r.index = 4'(c);
        r.value = chan[c];
        r.last = (c == NUM_CHANNELS - 1);
        link_results_q.push_back(r);
      end
    end
  endfunction

  function automatic string describe_word(input rx_result_t r);
    return $sformatf("kind %0d status %0d link %0d frames %0d ch %0d value %0d last %0d",
                     r.kind, r.status, r.link_ok, r.frames, r.index, r.value, r.last);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic act, input logic [7:0] b, input bit typed = 1'b0,
                           input rx_result_t typed_word = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_data_byte = b;
    do @(posedge clk); while (in_stall);
    words_in++;
    @(negedge clk);
    predict_link_results(act, b);
    if (typed) begin
      // status typed from the table replaces the predicted one
      void'(link_results_q.pop_back());
      link_results_q.push_back(typed_word);
    end
  endtask

  task automatic send_frame(input logic [5:0] len, input logic [7:0] ftype, input bit crc_ok,
                            input int tick_pct, input bit fixed, input logic [7:0] fill);
    logic [7:0] body [$];
    logic [7:0] crc;
    body.push_back(ftype);
    for (int k = 0; k < int'(len) - 2; k++) begin
      if (fixed) body.push_back(k < 11 ? fill : ~fill);
      else body.push_back(8'($urandom_range(255)));
    end
    crc = '0;
    foreach (body[i]) crc = crc8_next(crc, body[i]);
    if (!crc_ok) crc ^= 8'($urandom_range(1, 255));
    body.push_back(crc);
    send_word(ACT_BYTE, SYNC_MARK);
    send_word(ACT_BYTE, {2'b00, len});
    foreach (body[i]) begin
      if ($urandom_range(99) < tick_pct) send_word(ACT_TICK, 8'($urandom_range(255)));
      send_word(ACT_BYTE, body[i]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (cfg_idx_t'(idx))
      CFG_TIMEOUT:    timeout_ms = val;
      CFG_CH_DEFAULT: chan_default = val[CH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (link_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_traffic(input int n_words);
    int         stop;
    int         r;
    logic [7:0] t;
    stop = words_in + n_words;
    while (words_in < stop) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_frame(6'd24, TYPE_RC, 1'b1, 12, 1'b0, 8'h00);
      end else if (r < 55) begin
        send_frame(6'($urandom_range(25, 62)), TYPE_RC, 1'b1, 12, 1'b0, 8'h00);
      end else if (r < 63) begin
        send_frame(6'($urandom_range(24, 30)), TYPE_RC, 1'b0, 12, 1'b0, 8'h00);
      end else if (r < 70) begin
        t = 8'($urandom_range(255));
        if (t == TYPE_RC) t ^= 8'h01;
        send_frame(6'($urandom_range(2, 62)), t, 1'($urandom_range(1)), 12, 1'b0, 8'h00);
      end else if (r < 75) begin
        send_frame(6'($urandom_range(2, 23)), TYPE_RC, 1'b1, 12, 1'b0, 8'h00);
      end else if (r < 80) begin
        send_word(ACT_BYTE, SYNC_MARK);
        send_word(ACT_BYTE, $urandom_range(1) ? 8'($urandom_range(1))
                                              : 8'($urandom_range(63, 255)));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) send_word(ACT_BYTE, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(3, 40)) send_word(ACT_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind = out_kind;
      seen.status = frame_status_t'(out_frame_status);
      seen.link_ok = out_link_ok;
      seen.frames = out_valid_frames;
      seen.index = out_channel_index;
      seen.value = out_channel_value;
      seen.last = out_last;
      if (link_results_q.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("%0t: unexpected word: %s", $realtime, describe_word(seen));
      end else begin
        want = link_results_q.pop_front();
        checked++;
        if (seen !== want) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, want %s", $realtime, describe_word(want));
            $display("%0t:           got  %s", $realtime, describe_word(seen));
          end
        end
      end
    end
  end

  initial begin
    #800_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rx_result_t exp_word;
    int         leftover;
    in_valid = 1'b0;
    in_action = ACT_BYTE;
    in_data_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIMEOUT;
    cfg_data = '0;
    rst_n = 1'b0;
    words_in = 0;
    checked = 0;
    bad_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    rx_phase = HUNT_SYNC;
    frame_len = '0;
    body_pos = '0;
    body_crc = '0;
    body_type = '0;
    foreach (chan[c]) chan[c] = CH_DEFAULT_RST;
    since_ms = SINCE_SAT;
    frames_ok = '0;
    timeout_ms = TIMEOUT_RST;
    chan_default = CH_DEFAULT_RST;

    dir_table = '{
      '{ROW_WORD,  ACT_TICK, 8'h00,     ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, 8'h00,     ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, SYNC_MARK, ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, SYNC_MARK, ST_BADLEN, 1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, 8'hFF,     ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, SYNC_MARK, ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, 8'h01,     ST_BADLEN, 1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, SYNC_MARK, ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, 8'h3F,     ST_BADLEN, 1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, SYNC_MARK, ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, 8'h02,     ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_TICK, 8'h00,     ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, TYPE_RC,   ST_NONE,   1'b0, 32'd0},
      '{ROW_WORD,  ACT_BYTE, 8'hFF,     ST_DROP,   1'b0, 32'd0},
      '{ROW_FRAME, ACT_BYTE, 8'hFF,     ST_ACCEPT, 1'b1, 32'd1},
      '{ROW_WORD,  ACT_TICK, 8'h00,     ST_NONE,   1'b1, 32'd1},
      '{ROW_WORD,  ACT_TICK, 8'h00,     ST_NONE,   1'b1, 32'd1}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset register values; channels 0-7 at full scale, 8-15 at zero
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WORD) begin
        exp_word = '0;
        exp_word.status = dir_table[i].st;
        exp_word.link_ok = dir_table[i].link_ok;
        exp_word.frames = dir_table[i].frames;
        exp_word.last = 1'b1;
        send_word(dir_table[i].action, dir_table[i].data, 1'b1, exp_word);
      end else begin
        send_frame(6'd24, TYPE_RC, 1'b1, 0, 1'b1, dir_table[i].data);
      end
    end
    wait_drained();

    // timeout of one tick, unused indexes; long output hold against a busy sender
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_CH_DEFAULT, 16'd0);
    write_reg(CFG_SPARE_A, 16'($urandom_range(65535)));
    write_reg(CFG_SPARE_B, 16'($urandom_range(65535)));
    hold_left = 400;
    run_traffic(105);
    wait_drained();

    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_CH_DEFAULT, 16'hFFFF);
    send_idle_pct = 64;
    run_traffic(105);
    wait_drained();

    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_CH_DEFAULT, 16'($urandom_range(65535)));
    send_idle_pct = 0;
    stall_pct = 64;
    run_traffic(105);
    wait_drained();

    write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
    write_reg(CFG_CH_DEFAULT, 16'($urandom_range(65535)));
    send_idle_pct = 6;
    stall_pct = 6;
    run_traffic(105);

    in_valid = 1'b0;
    while (link_results_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    leftover = link_results_q.size();

    $display("summary: %0d words sent, %0d result words checked, %0d channel frames accepted",
             words_in, checked, frames_ok);
    $display("summary: timeouts 0, 1, 500, 65535 and a small random one; idle, stall, hold mixes");
    if (bad_count == 0 && leftover == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rclfr_pkg.sv
hw/rtl/rclfr_ram.sv
hw/rtl/rclfr_crc_unit.sv
hw/rtl/rc_link_frame_receiver.sv
dv/tb_top.sv
